// ===== rtl/mbae_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus ASCII encoder package
// Shared types, character constants and the nibble-to-hex helper.
// ----------------------------------------------------------------------------
package mbae_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [6:0] CHAR_COLON     = 7'h3A;
   localparam logic [6:0] CHAR_CR        = 7'h0D;
   localparam logic [6:0] CHAR_LF        = 7'h0A;
   localparam logic [6:0] HEX_DIGIT_BASE = 7'h30;
   localparam logic [6:0] HEX_ALPHA_BASE = 7'h41;

   // One queued job: which character groups to emit and the bytes they need
   typedef struct packed {
      logic       open;
      logic       has_data;
      logic       last;
      logic [7:0] addr;
      logic [7:0] func;
      logic [7:0] data;
      logic [7:0] lrc;
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START,
      PH_ADDR_HI,
      PH_ADDR_LO,
      PH_FUNC_HI,
      PH_FUNC_LO,
      PH_DATA_HI,
      PH_DATA_LO,
      PH_LRC_HI,
      PH_LRC_LO,
      PH_CR,
      PH_LF
   } phase_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] ch;
      if (nib < 4'd10) begin
         ch = HEX_DIGIT_BASE + 7'(nib);
      end else begin
         ch = HEX_ALPHA_BASE + (7'(nib) - 7'd10);
      end
      return ch;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mbae_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus ASCII encoder channels
// Valid/ready channels for items, characters and the address register.
// ----------------------------------------------------------------------------
interface mbae_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] function_code;
   logic [7:0] data_byte;
   logic       has_data;
   logic       last_item;

   modport source (output valid, function_code, data_byte, has_data, last_item,
                   input ready);
   modport sink   (input valid, function_code, data_byte, has_data, last_item,
                   output ready);
endinterface

interface mbae_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] ascii_char;
   logic       last_of_run;
   logic       end_of_frame;

   modport source (output valid, ascii_char, last_of_run, end_of_frame, input ready);
   modport sink   (input valid, ascii_char, last_of_run, end_of_frame, output ready);
endinterface

interface mbae_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] write_data;

   modport source (output valid, write_data, input ready);
   modport sink   (input valid, write_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mbae_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Small FIFO of encoding jobs between front and back.
// ----------------------------------------------------------------------------
module mbae_queue #(
   parameter int unsigned Depth = mbae_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire mbae_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output mbae_pkg::cmd_type     head_cmd
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   mbae_pkg::cmd_type entry_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Never write into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue overflow");

endmodule
`default_nettype wire

// ===== rtl/mbae_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts items, tracks frame state and the running LRC, queues jobs.
// ----------------------------------------------------------------------------
module mbae_front (
   input  wire logic          clock,
   input  wire logic          reset,
   mbae_req_if.sink           req_chan,
   mbae_csr_if.sink           csr_chan,
   input  wire logic          q_full,
   output logic               q_push,
   output mbae_pkg::cmd_type  q_cmd
);

   logic       in_frame_ff, in_frame_in;
   logic [7:0] lrc_sum_ff, lrc_sum_in;
   logic [7:0] dev_addr_ff, dev_addr_in;
   logic       accept;
   logic       open;
   logic [7:0] base_sum;
   logic [7:0] item_sum;

   assign req_chan.ready = !q_full;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;
   assign open           = !in_frame_ff;

   always_comb begin
      base_sum = open ? (dev_addr_ff + req_chan.function_code) : lrc_sum_ff;
      item_sum = req_chan.has_data ? (base_sum + req_chan.data_byte) : base_sum;
   end

   always_comb begin
      q_cmd.open     = open;
      q_cmd.has_data = req_chan.has_data;
      q_cmd.last     = req_chan.last_item;
      q_cmd.addr     = dev_addr_ff;
      q_cmd.func     = req_chan.function_code;
      q_cmd.data     = req_chan.data_byte;
      q_cmd.lrc      = (~item_sum) + 8'd1;
      // drop items that produce no characters
      q_push = accept && (open || req_chan.has_data || req_chan.last_item);
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      lrc_sum_in  = lrc_sum_ff;
      dev_addr_in = dev_addr_ff;
      if (accept) begin
         in_frame_in = !req_chan.last_item;
         lrc_sum_in  = req_chan.last_item ? 8'd0 : item_sum;
      end
      if (csr_chan.valid && csr_chan.ready) begin
         dev_addr_in = csr_chan.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         lrc_sum_ff  <= 8'd0;
         dev_addr_ff <= 8'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         lrc_sum_ff  <= lrc_sum_in;
         dev_addr_ff <= dev_addr_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mbae_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder back end
// Walks each queued job one character per cycle into the output register, unless the output stalls.
// ----------------------------------------------------------------------------
module mbae_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire mbae_pkg::cmd_type q_cmd,
   output logic               q_pop,
   mbae_rsp_if.source         rsp_chan
);

   mbae_pkg::phase_type state_ff, state_in;
   mbae_pkg::phase_type follow;
   mbae_pkg::phase_type first;
   mbae_pkg::cmd_type   cmd_ff;

   logic       advance;
   logic       finishing;
   logic [6:0] char_sel;
   logic       eof_sel;

   logic       out_valid_ff, out_valid_in;
   logic [6:0] out_char_ff;
   logic       out_lor_ff;
   logic       out_eof_ff;

   assign advance = (state_ff != mbae_pkg::PH_IDLE) && (!out_valid_ff || rsp_chan.ready);

   // Phase after the current one; idle means the job is done
   always_comb begin
      case (state_ff)
         mbae_pkg::PH_START:   follow = mbae_pkg::PH_ADDR_HI;
         mbae_pkg::PH_ADDR_HI: follow = mbae_pkg::PH_ADDR_LO;
         mbae_pkg::PH_ADDR_LO: follow = mbae_pkg::PH_FUNC_HI;
         mbae_pkg::PH_FUNC_HI: follow = mbae_pkg::PH_FUNC_LO;
         mbae_pkg::PH_FUNC_LO: begin
            follow = cmd_ff.has_data ? mbae_pkg::PH_DATA_HI
                   : (cmd_ff.last ? mbae_pkg::PH_LRC_HI : mbae_pkg::PH_IDLE);
         end
         mbae_pkg::PH_DATA_HI: follow = mbae_pkg::PH_DATA_LO;
         mbae_pkg::PH_DATA_LO: follow = cmd_ff.last ? mbae_pkg::PH_LRC_HI : mbae_pkg::PH_IDLE;
         mbae_pkg::PH_LRC_HI:  follow = mbae_pkg::PH_LRC_LO;
         mbae_pkg::PH_LRC_LO:  follow = mbae_pkg::PH_CR;
         mbae_pkg::PH_CR:      follow = mbae_pkg::PH_LF;
         default:              follow = mbae_pkg::PH_IDLE;
      endcase
      first = q_cmd.open ? mbae_pkg::PH_START
            : (q_cmd.has_data ? mbae_pkg::PH_DATA_HI : mbae_pkg::PH_LRC_HI);
      finishing = (follow == mbae_pkg::PH_IDLE);
   end

   // Next state
   always_comb begin
      q_pop    = 1'b0;
      state_in = state_ff;
      if ((state_ff == mbae_pkg::PH_IDLE) || (advance && finishing)) begin
         q_pop    = q_valid;
         state_in = q_valid ? first : mbae_pkg::PH_IDLE;
      end else if (advance) begin
         state_in = follow;
      end
   end

   // Outputs of the current phase
   always_comb begin
      eof_sel = 1'b0;
      case (state_ff)
         mbae_pkg::PH_START:   char_sel = mbae_pkg::CHAR_COLON;
         mbae_pkg::PH_ADDR_HI: char_sel = mbae_pkg::hex_char(cmd_ff.addr[7:4]);
         mbae_pkg::PH_ADDR_LO: char_sel = mbae_pkg::hex_char(cmd_ff.addr[3:0]);
         mbae_pkg::PH_FUNC_HI: char_sel = mbae_pkg::hex_char(cmd_ff.func[7:4]);
         mbae_pkg::PH_FUNC_LO: char_sel = mbae_pkg::hex_char(cmd_ff.func[3:0]);
         mbae_pkg::PH_DATA_HI: char_sel = mbae_pkg::hex_char(cmd_ff.data[7:4]);
         mbae_pkg::PH_DATA_LO: char_sel = mbae_pkg::hex_char(cmd_ff.data[3:0]);
         mbae_pkg::PH_LRC_HI:  char_sel = mbae_pkg::hex_char(cmd_ff.lrc[7:4]);
         mbae_pkg::PH_LRC_LO:  char_sel = mbae_pkg::hex_char(cmd_ff.lrc[3:0]);
         mbae_pkg::PH_CR:      char_sel = mbae_pkg::CHAR_CR;
         mbae_pkg::PH_LF: begin
            char_sel = mbae_pkg::CHAR_LF;
            eof_sel  = 1'b1;
         end
         default:              char_sel = 7'd0;
      endcase
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbae_pkg::PH_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
      if (advance) begin
         out_char_ff <= char_sel;
         out_lor_ff  <= finishing;
         out_eof_ff  <= eof_sel;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.ascii_char   = out_char_ff;
   assign rsp_chan.last_of_run  = out_lor_ff;
   assign rsp_chan.end_of_frame = out_eof_ff;

   // Pop only an occupied queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");

   // Every character issued shows up on the output
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_chan.valid)
      else $error("character lost");

   // Closing LF marks both end of frame and end of run
   assert property (@(posedge clock) disable iff (reset)
      (advance && (state_ff == mbae_pkg::PH_LF))
      |=> (rsp_chan.end_of_frame && rsp_chan.last_of_run))
      else $error("frame end not flagged");

endmodule
`default_nettype wire

// ===== rtl/modbus_ascii_frame_encoder_top.sv =====
`default_nettype none
// An item's first character passes the command queue, the back-end state register
//   and the output register before it is valid. Output: one character per cycle
//   unless the output stalls; a data-only item carries 2 characters.
// Items are taken whenever the command queue has room, also while characters wait.
// Reset (synchronous) closes any open frame, clears the LRC sum and the address
//   register, empties the queue and drops the pending output character.
// ----------------------------------------------------------------------------
// Modbus ASCII frame encoder
// Turns header/data/close items into ':' + hex + LRC + CR LF character stream.
// ----------------------------------------------------------------------------
module modbus_ascii_frame_encoder_top #(
   parameter int unsigned QueueDepth = mbae_pkg::QUEUE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mbae_req_if.sink   req_chan,
   mbae_rsp_if.source rsp_chan,
   mbae_csr_if.sink   csr_chan
);

   // Front to queue
   logic              q_push;
   logic              q_full;
   mbae_pkg::cmd_type q_push_cmd;

   // Queue to back
   logic              q_pop;
   logic              q_valid;
   mbae_pkg::cmd_type q_head_cmd;

   // Front: take items, open/close frames, fold bytes into the LRC sum and
   // hand one job per productive item to the queue.
   mbae_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_push_cmd)
   );

   // Queue: decouple item transfers from character output.
   mbae_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd)
   );

   // Back: advance through the job's characters, one per output transfer.
   mbae_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_cmd    (q_head_cmd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
